FILE: rtl/ppsp_pkg.sv
`default_nettype none
package ppsp_pkg;

    localparam int KIND_BITS  = 3;
    localparam int VALUE_BITS = 16;
    localparam int ROW_BITS   = 16;
    localparam int POS_BITS   = 18;
    localparam int ERR_BITS   = 4;
    localparam int FMT_BITS   = 2;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [VALUE_BITS-1:0] value;
        logic [ROW_BITS-1:0]   row;
        logic [POS_BITS-1:0]   position;
        logic [ERR_BITS-1:0]   error_code;
        logic                  last;
    } t_result;

    // result kinds
    localparam logic [KIND_BITS-1:0] KIND_FORMAT   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_WIDTH    = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_HEIGHT   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MAXVAL   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_SAMPLE   = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_COMPLETE = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_ERROR    = 3'd6;

    // error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE        = 4'd0;
    localparam logic [ERR_BITS-1:0] ERR_EARLY_END   = 4'd1;
    localparam logic [ERR_BITS-1:0] ERR_MAGIC_LINE  = 4'd2;
    localparam logic [ERR_BITS-1:0] ERR_BAD_MAGIC   = 4'd3;
    localparam logic [ERR_BITS-1:0] ERR_FMT_MISMATCH = 4'd4;
    localparam logic [ERR_BITS-1:0] ERR_BAD_DIMS    = 4'd5;
    localparam logic [ERR_BITS-1:0] ERR_BAD_MAX     = 4'd6;
    localparam logic [ERR_BITS-1:0] ERR_BAD_SAMPLE  = 4'd7;
    localparam logic [ERR_BITS-1:0] ERR_TOO_LARGE   = 4'd8;

    // characters
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [FMT_BITS-1:0] FMT_PBM = 2'd1;

    function automatic t_result make_result(
        input logic [KIND_BITS-1:0]  kind,
        input logic [VALUE_BITS-1:0] value,
        input logic [ROW_BITS-1:0]   row,
        input logic [POS_BITS-1:0]   position,
        input logic [ERR_BITS-1:0]   error_code,
        input logic                  last
    );
        t_result r;
        r.kind       = kind;
        r.value      = value;
        r.row        = row;
        r.position   = position;
        r.error_code = error_code;
        r.last       = last;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ppsp_byte_if.sv
`default_nettype none
interface ppsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_file;

    modport source (output valid, output byte_value, output end_of_file, input ready);
    modport sink   (input valid, input byte_value, input end_of_file, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppsp_cfg_if.sv
`default_nettype none
interface ppsp_cfg_if;
    import ppsp_pkg::*;
    logic                valid;
    logic                ready;
    logic [FMT_BITS-1:0] expected_format;

    modport source (output valid, output expected_format, input ready);
    modport sink   (input valid, input expected_format, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppsp_result_if.sv
`default_nettype none
interface ppsp_result_if;
    import ppsp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [VALUE_BITS-1:0] value;
    logic [ROW_BITS-1:0]   row;
    logic [POS_BITS-1:0]   position;
    logic [ERR_BITS-1:0]   error_code;
    logic                  last;

    modport source (output valid, output kind, output value, output row, output position,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input value, input row, input position,
                    input error_code, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/ppsp_out_queue.sv
`default_nettype none
module ppsp_out_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  ppsp_pkg::t_result          i_data0,
    input  ppsp_pkg::t_result          i_data1,
    input  logic                       i_pop,
    output logic                       o_valid,
    output ppsp_pkg::t_result          o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import ppsp_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH+1);

    t_result               r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wr, r_rd, n_wr, w_wr1;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  w_pop;

    function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wr1   = wrap_inc(r_wr);
    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_comb begin
        case (i_push_cnt)
            2'd1:    n_wr = w_wr1;
            2'd2:    n_wr = wrap_inc(w_wr1);
            default: n_wr = r_wr;
        endcase
        n_count = r_count + CNT_BITS'(i_push_cnt) - CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (w_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push_cnt != 2'd0 && r_wr == PTR_BITS'(i)) begin
                r_mem[i] <= i_data0;
            end else if (i_push_cnt == 2'd2 && w_wr1 == PTR_BITS'(i)) begin
                r_mem[i] <= i_data1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/plain_pnm_stream_parser.sv
`default_nettype none
// Plain PNM (P1/P2/P3) stream parser. Takes one file byte per clock and
// updates a small parse state in that same cycle; each byte yields zero, one
// or two result words (a number closed by its terminator can be followed by
// an error or image-complete word). Results go into a QUEUE_DEPTH-entry
// output queue, and a byte is taken only while at least two entries are free,
// so the input runs at one byte per clock as long as the sink takes one word
// per clock; the output side delivers at most one word per clock. The format
// register may be written at any time the parser is idle and is kept across
// end of file.
module plain_pnm_stream_parser #(
    parameter int DIM_BITS    = 16,
    parameter int VALUE_BITS  = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ppsp_byte_if.sink     i_byte,
    ppsp_cfg_if.sink      i_cfg,
    ppsp_result_if.source o_result
);
    import ppsp_pkg::*;

    localparam int ACC_BITS  = ((DIM_BITS > VALUE_BITS) ? DIM_BITS : VALUE_BITS) + 4;
    localparam int CNT_BITS  = DIM_BITS + 2;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH+1);

    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_MAGIC2  = 4'd1;
    localparam logic [3:0] PH_SKIPW   = 4'd2;
    localparam logic [3:0] PH_WIDTH   = 4'd3;
    localparam logic [3:0] PH_BETWEEN = 4'd4;
    localparam logic [3:0] PH_HEIGHT  = 4'd5;
    localparam logic [3:0] PH_SKIPM   = 4'd6;
    localparam logic [3:0] PH_MAX     = 4'd7;
    localparam logic [3:0] PH_SKIPS   = 4'd8;
    localparam logic [3:0] PH_SAMPLE  = 4'd9;
    localparam logic [3:0] PH_DONE    = 4'd10;

    logic [FMT_BITS-1:0] r_exp_fmt;
    logic [3:0]          r_phase, n_phase;
    logic                r_comment, n_comment;
    logic                r_brk, n_brk;
    logic [7:0]          r_first, n_first;
    logic [FMT_BITS-1:0] r_fmt, n_fmt;
    logic [DIM_BITS-1:0] r_width, n_width;
    logic [DIM_BITS-1:0] r_height, n_height;
    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [DIM_BITS-1:0] r_row, n_row;
    logic [CNT_BITS-1:0] r_pos, n_pos;

    logic                 w_in_acc;
    logic [1:0]           w_nres;
    t_result              w_res [2];
    logic [1:0]           w_push_cnt;
    logic [QCNT_BITS-1:0] w_count;
    logic                 w_q_valid;
    t_result              w_q_data;

    assign w_in_acc     = i_byte.valid && i_byte.ready;
    assign i_byte.ready = (w_count <= QCNT_BITS'(QUEUE_DEPTH-2));
    assign i_cfg.ready  = 1'b1;
    assign w_push_cnt   = w_in_acc ? w_nres : 2'd0;

    always_comb begin
        logic [7:0]          b;
        logic                eof;
        logic [3:0]          ph;
        logic                go_b;
        logic                is_dig;
        logic                is_sp;
        logic                is_gr;
        logic                is_br;
        logic [3:0]          dig;
        logic [ACC_BITS-1:0] acc10;
        logic                too_big;
        logic [CNT_BITS-1:0] len;
        logic [CNT_BITS-1:0] pos_inc;
        logic [DIM_BITS-1:0] row_nx;
        logic [FMT_BITS-1:0] fmt;

        b      = i_byte.byte_value;
        eof    = i_byte.end_of_file;
        is_dig = (b inside {[CH_0:CH_9]});
        is_sp  = (b == CH_SP) || (b inside {[CH_TAB:CH_CR]});
        is_gr  = (b inside {[CH_BANG:CH_TILDE]});
        is_br  = (b == CH_LF) || (b == CH_CR);
        dig    = b[3:0];
        acc10  = {r_acc[ACC_BITS-4:0], 3'b000} + {r_acc[ACC_BITS-2:0], 1'b0}
                 + ACC_BITS'(dig);
        len    = (r_fmt == 2'd3) ? ({r_width, 1'b0} + CNT_BITS'(r_width))
                                 : CNT_BITS'(r_width);
        pos_inc = r_pos + 1'b1;
        row_nx  = r_row;
        fmt     = '0;
        too_big = 1'b0;

        n_phase   = r_phase;
        n_comment = r_comment;
        n_brk     = r_brk;
        n_first   = r_first;
        n_fmt     = r_fmt;
        n_width   = r_width;
        n_height  = r_height;
        n_acc     = r_acc;
        n_row     = r_row;
        n_pos     = r_pos;
        w_res[0]  = '0;
        w_res[1]  = '0;
        w_nres    = 2'd0;

        ph   = r_phase;
        go_b = 1'b1;

        // number tokens: accumulate, flag an overflow, or close; closing byte then re-read below
        if (ph == PH_WIDTH || ph == PH_HEIGHT || ph == PH_MAX || ph == PH_SAMPLE) begin
            go_b = 1'b0;
            if (!eof && is_dig) begin
                if (ph == PH_WIDTH || ph == PH_HEIGHT) begin
                    too_big = ((acc10 >> DIM_BITS) != '0);
                end else begin
                    too_big = ((acc10 >> VALUE_BITS) != '0);
                end
                if (too_big) begin
                    w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0, ERR_TOO_LARGE, 1'b1);
                    w_nres = w_nres + 1'b1;
                    ph = PH_DONE;
                end else begin
                    n_acc = acc10;
                end
            end else begin
                case (ph)
                    PH_WIDTH: begin
                        n_width = r_acc[DIM_BITS-1:0];
                        w_res[w_nres[0]] = make_result(KIND_WIDTH, 16'(r_acc), '0, '0,
                                                       ERR_NONE, 1'b0);
                        w_nres = w_nres + 1'b1;
                        ph = PH_BETWEEN;
                    end
                    PH_HEIGHT: begin
                        n_height = r_acc[DIM_BITS-1:0];
                        w_res[w_nres[0]] = make_result(KIND_HEIGHT, 16'(r_acc), '0, '0,
                                                       ERR_NONE, 1'b0);
                        w_nres = w_nres + 1'b1;
                        if (r_fmt == FMT_PBM) begin
                            n_row = '0;
                            n_pos = '0;
                            if (r_width == '0 || r_acc[DIM_BITS-1:0] == '0) begin
                                w_res[w_nres[0]] = make_result(KIND_COMPLETE, '0, '0, '0,
                                                               ERR_NONE, 1'b1);
                                w_nres = w_nres + 1'b1;
                                ph = PH_DONE;
                            end else begin
                                ph = PH_SKIPS;
                            end
                        end else begin
                            ph = PH_SKIPM;
                        end
                    end
                    PH_MAX: begin
                        w_res[w_nres[0]] = make_result(KIND_MAXVAL, 16'(r_acc), '0, '0,
                                                       ERR_NONE, 1'b0);
                        w_nres = w_nres + 1'b1;
                        n_row = '0;
                        n_pos = '0;
                        if (r_width == '0 || r_height == '0) begin
                            w_res[w_nres[0]] = make_result(KIND_COMPLETE, '0, '0, '0,
                                                           ERR_NONE, 1'b1);
                            w_nres = w_nres + 1'b1;
                            ph = PH_DONE;
                        end else begin
                            ph = PH_SKIPS;
                        end
                    end
                    default: begin
                        w_res[w_nres[0]] = make_result(KIND_SAMPLE, 16'(r_acc), 16'(r_row),
                                                       18'(r_pos), ERR_NONE, 1'b0);
                        w_nres = w_nres + 1'b1;
                        if (pos_inc >= len) begin
                            n_pos  = '0;
                            row_nx = r_row + 1'b1;
                        end else begin
                            n_pos = pos_inc;
                        end
                        n_row = row_nx;
                        if (row_nx >= r_height) begin
                            w_res[w_nres[0]] = make_result(KIND_COMPLETE, '0, '0, '0,
                                                           ERR_NONE, 1'b1);
                            w_nres = w_nres + 1'b1;
                            ph = PH_DONE;
                        end else begin
                            ph = PH_SKIPS;
                        end
                    end
                endcase
                go_b = (ph != PH_DONE);
            end
        end

        // token start: skipping, magic number, gap between width and height
        if (go_b) begin
            case (ph)
                PH_START, PH_SKIPW, PH_SKIPM, PH_SKIPS: begin
                    if (eof) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                       ERR_EARLY_END, 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else if (n_comment) begin
                        if (is_br) begin
                            n_comment = 1'b0;
                            n_brk     = 1'b1;
                        end
                    end else if (is_br) begin
                        n_brk = 1'b1;
                    end else if (!is_gr) begin
                        ph = ph;
                    end else if (b == CH_HASH) begin
                        n_comment = 1'b1;
                    end else if (ph == PH_START) begin
                        if (n_brk) begin
                            w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                           ERR_MAGIC_LINE, 1'b1);
                            w_nres = w_nres + 1'b1;
                            ph = PH_DONE;
                        end else begin
                            n_first = b;
                            ph = PH_MAGIC2;
                        end
                    end else if (!is_dig) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                            (ph == PH_SKIPW) ? ERR_BAD_DIMS :
                            ((ph == PH_SKIPM) ? ERR_BAD_MAX : ERR_BAD_SAMPLE), 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else begin
                        n_acc = ACC_BITS'(dig);
                        ph = ph + 1'b1;
                    end
                end
                PH_MAGIC2: begin
                    if (!eof && b != CH_HASH && r_first == CH_P && (b inside {[CH_1:CH_3]})) begin
                        fmt = b[1:0];
                    end
                    if (fmt == '0) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                       ERR_BAD_MAGIC, 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else if ((fmt - 1'b1) != r_exp_fmt) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                       ERR_FMT_MISMATCH, 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else begin
                        n_fmt = fmt;
                        w_res[w_nres[0]] = make_result(KIND_FORMAT, 16'(fmt), '0, '0,
                                                       ERR_NONE, 1'b0);
                        w_nres = w_nres + 1'b1;
                        ph = PH_SKIPW;
                    end
                end
                PH_BETWEEN: begin
                    if (eof) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                       ERR_EARLY_END, 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else if (is_sp) begin
                        ph = PH_BETWEEN;
                    end else if (!is_dig) begin
                        w_res[w_nres[0]] = make_result(KIND_ERROR, '0, '0, '0,
                                                       ERR_BAD_DIMS, 1'b1);
                        w_nres = w_nres + 1'b1;
                        ph = PH_DONE;
                    end else begin
                        n_acc = ACC_BITS'(dig);
                        ph = PH_HEIGHT;
                    end
                end
                default: begin
                    ph = PH_DONE;
                end
            endcase
        end

        n_phase = ph;

        // end of file: back to the start, expected-format register kept
        if (eof) begin
            n_phase   = PH_START;
            n_comment = 1'b0;
            n_brk     = 1'b0;
            n_first   = '0;
            n_fmt     = '0;
            n_width   = '0;
            n_height  = '0;
            n_acc     = '0;
            n_row     = '0;
            n_pos     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_fmt <= '0;
            r_phase   <= PH_START;
            r_comment <= 1'b0;
            r_brk     <= 1'b0;
            r_first   <= '0;
            r_fmt     <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_acc     <= '0;
            r_row     <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_exp_fmt <= i_cfg.expected_format;
            end
            if (w_in_acc) begin
                r_phase   <= n_phase;
                r_comment <= n_comment;
                r_brk     <= n_brk;
                r_first   <= n_first;
                r_fmt     <= n_fmt;
                r_width   <= n_width;
                r_height  <= n_height;
                r_acc     <= n_acc;
                r_row     <= n_row;
                r_pos     <= n_pos;
            end
        end
    end

    ppsp_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_data0    (w_res[0]),
        .i_data1    (w_res[1]),
        .i_pop      (o_result.ready),
        .o_valid    (w_q_valid),
        .o_data     (w_q_data),
        .o_count    (w_count)
    );

    assign o_result.valid      = w_q_valid;
    assign o_result.kind       = w_q_data.kind;
    assign o_result.value      = w_q_data.value;
    assign o_result.row        = w_q_data.row;
    assign o_result.position   = w_q_data.position;
    assign o_result.error_code = w_q_data.error_code;
    assign o_result.last       = w_q_data.last;

`ifndef SYNTHESIS
    // a byte is taken only with room for two words
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (w_count <= QCNT_BITS'(QUEUE_DEPTH-2)))
        else $error("byte accepted without room for two words");

    // nothing is produced after the image has closed
    a_quiet_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_byte.end_of_file && r_phase == PH_DONE) |-> (w_push_cnt == 2'd0))
        else $error("word produced after image closed");

    // a closing word is never followed by another in the same byte
    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_cnt == 2'd2) |-> !w_res[0].last)
        else $error("word follows a closing word");

    // end of file always rewinds the parser
    a_eof_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_byte.end_of_file) |=> (r_phase == PH_START))
        else $error("parser not rewound after end of file");
`endif

endmodule
`default_nettype wire
